// ===== hdl/suss_pkg.sv =====
// shared types, codes and defaults of the stream universe send scheduler
// no dependencies; used by every module of the block except suss_ram
package suss_pkg;

	localparam int NUM_SLOTS_DEF       = 16;
	localparam int SEQ_GROUP_COUNT_DEF = 16;

	localparam int UNI_W      = 16;
	localparam int GRP_IN_W   = 4;
	localparam int SLOT_IN_W  = 4;
	localparam int SEQ_W      = 8;
	localparam int ELAPSED_W  = 16;
	localparam int INTERVAL_W = 16;
	localparam int TICK_W     = 10;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] REPEAT_LIMIT = 2'd3;
	localparam logic [1:0] TERM_LIMIT   = 2'd3;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd850;
	localparam logic [TICK_W-1:0]     TICK_RST     = 10'd10;

	localparam logic [CFG_IDX_W-1:0] CFG_SEND_INTERVAL = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD   = 4'd1;

	typedef enum logic [1:0] {
		CMD_CREATE = 2'd0,
		CMD_DIRTY  = 2'd1,
		CMD_TERM   = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CS_OK   = 2'd0,
		CS_ZERO = 2'd1,
		CS_FULL = 2'd2
	} create_status_t;

	typedef enum logic {
		KIND_REPLY = 1'b0,
		KIND_SEND  = 1'b1
	} kind_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [SLOT_IN_W-1:0] slot;
		logic [UNI_W-1:0]     universe_number;
		logic [GRP_IN_W-1:0]  seq_group;
		logic                 skip_repeats;
	} item_t;

	typedef struct packed {
		kind_t                kind;
		logic [SLOT_IN_W-1:0] out_slot;
		logic [UNI_W-1:0]     out_universe;
		logic [SEQ_W-1:0]     sequence_res;
		logic                 terminating;
		create_status_t       status;
		logic                 last;
	} result_t;

	// one slot table entry
	typedef struct packed {
		logic [UNI_W-1:0]     universe;
		logic [GRP_IN_W-1:0]  group;
		logic                 no_inactivity;
		logic                 dirty;
		logic                 ever_dirty;
		logic [1:0]           repeat_count;
		logic [ELAPSED_W-1:0] elapsed;
		logic                 terminated;
		logic [1:0]           term_sends;
	} slot_word_t;

	typedef struct packed {
		logic           latch;
		logic           create_wr;
		logic           reply;
		create_status_t status;
		logic           rmw_rd;
		logic           rmw_wr;
		logic           walk_rd;
		logic           flush;
	} ctl_t;

	typedef struct packed {
		logic uni_zero;
		logic slot_free;
		logic walk_busy;
	} sts_t;

endpackage

// ===== hdl/suss_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module suss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                     wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                     rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== hdl/suss_ctrl.sv =====
// controller state machine of the send scheduler: sequences create scans,
// flag updates and the tick walk; depends on suss_pkg
module suss_ctrl #(
	parameter int NUM_SLOTS = suss_pkg::NUM_SLOTS_DEF,
	parameter int SLOT_W    = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  suss_pkg::cmd_t     cmd,
	input  suss_pkg::sts_t     sts,
	output logic               busy,
	output suss_pkg::ctl_t     ctl,
	output logic [SLOT_W-1:0]  idx
);
	import suss_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SCAN   = 7'b0000010,
		ST_RMW_RD = 7'b0000100,
		ST_RMW_WR = 7'b0001000,
		ST_WALK   = 7'b0010000,
		ST_DRAIN  = 7'b0100000,
		ST_FLUSH  = 7'b1000000
	} state_t;

	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

	state_t            state_q, state_d;
	logic [SLOT_W-1:0] cnt_q, cnt_d;

	always_comb begin
		ctl     = '0;
		ctl.status = CS_OK;
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					cnt_d     = '0;
					case (cmd)
						CMD_CREATE:          state_d = ST_SCAN;
						CMD_DIRTY, CMD_TERM: state_d = ST_RMW_RD;
						CMD_TICK:            state_d = ST_WALK;
						default:             state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (sts.uni_zero) begin
					ctl.reply  = 1'b1;
					ctl.status = CS_ZERO;
					state_d    = ST_IDLE;
				end else if (sts.slot_free) begin
					ctl.create_wr = 1'b1;
					ctl.reply     = 1'b1;
					ctl.status    = CS_OK;
					state_d       = ST_IDLE;
				end else if (cnt_q == LAST_IDX) begin
					ctl.reply  = 1'b1;
					ctl.status = CS_FULL;
					state_d    = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_RMW_RD: begin
				ctl.rmw_rd = 1'b1;
				state_d    = ST_RMW_WR;
			end
			ST_RMW_WR: begin
				ctl.rmw_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_WALK: begin
				ctl.walk_rd = 1'b1;
				if (cnt_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!sts.walk_busy) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				ctl.flush = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign idx  = cnt_q;

endmodule

// ===== hdl/suss_dpath.sv =====
// datapath of the send scheduler: slot table, sequence counters, the
// two-stage walk pipeline and the result register; depends on suss_pkg, suss_ram
module suss_dpath #(
	parameter int NUM_SLOTS       = suss_pkg::NUM_SLOTS_DEF,
	parameter int SEQ_GROUP_COUNT = suss_pkg::SEQ_GROUP_COUNT_DEF,
	parameter int SLOT_W          = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  suss_pkg::item_t                     item,
	input  suss_pkg::ctl_t                      ctl,
	input  logic [SLOT_W-1:0]                   idx,
	output suss_pkg::sts_t                      sts,
	input  logic                                cfg_valid,
	input  logic [suss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [suss_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                result_strobe,
	output suss_pkg::result_t                   result
);
	import suss_pkg::*;

	localparam int GRP_W  = (SEQ_GROUP_COUNT > 1) ? $clog2(SEQ_GROUP_COUNT) : 1;
	localparam int WORD_W = $bits(slot_word_t);

	// configuration
	logic [INTERVAL_W-1:0] interval_q;
	logic [TICK_W-1:0]     tick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RST;
			tick_q     <= TICK_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_SEND_INTERVAL) begin
				interval_q <= cfg_data[INTERVAL_W-1:0];
			end else if (cfg_index == CFG_TICK_PERIOD) begin
				tick_q <= cfg_data[TICK_W-1:0];
			end
		end
	end

	// latched item
	item_t item_q;

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			item_q <= item;
		end
	end

	logic [SLOT_W-1:0]   s_idx;
	logic [GRP_IN_W-1:0] grp_red;
	logic                rmw_ok;

	assign s_idx = SLOT_W'(item_q.slot);

	// group number reduced by the group count, as a small constant table
	always_comb begin
		grp_red = '0;
		for (int k = 0; k < (1 << GRP_IN_W); k++) begin
			if (item_q.seq_group == GRP_IN_W'(k)) begin
				grp_red = GRP_IN_W'(k % SEQ_GROUP_COUNT);
			end
		end
	end

	// slot table in-use bits
	logic [NUM_SLOTS-1:0] in_use_q;

	assign rmw_ok = (32'(item_q.slot) < NUM_SLOTS) && in_use_q[s_idx];

	// slot table ram
	logic              slot_wr_en;
	logic [SLOT_W-1:0] slot_wr_addr;
	slot_word_t        slot_wr_data;
	logic [SLOT_W-1:0] slot_rd_addr;
	slot_word_t        slot_rd_data;

	suss_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (slot_wr_en),
		.wr_addr (slot_wr_addr),
		.wr_data (slot_wr_data),
		.rd_addr (slot_rd_addr),
		.rd_data (slot_rd_data)
	);

	// sequence counter ram
	logic             grp_wr_en;
	logic [GRP_W-1:0] grp_wr_addr;
	logic [SEQ_W-1:0] grp_wr_data;
	logic [GRP_W-1:0] grp_rd_addr;
	logic [SEQ_W-1:0] grp_rd_data;

	suss_ram #(
		.WIDTH (SEQ_W),
		.DEPTH (SEQ_GROUP_COUNT)
	) u_seq_ram (
		.clk     (clk),
		.wr_en   (grp_wr_en),
		.wr_addr (grp_wr_addr),
		.wr_data (grp_wr_data),
		.rd_addr (grp_rd_addr),
		.rd_data (grp_rd_data)
	);

	// walk stage 1: slot entry arrives, decide and build the updated entry
	logic              v_s1_q;
	logic [SLOT_W-1:0] idx_s1;

	logic                 use_s1;
	logic                 free_s1;
	logic                 live_s1;
	logic                 go_s1;
	logic [ELAPSED_W:0]   aged_sum;
	logic [ELAPSED_W-1:0] aged;
	slot_word_t           upd_s1;

	always_comb begin
		use_s1   = in_use_q[idx_s1];
		free_s1  = use_s1 && (slot_rd_data.term_sends == TERM_LIMIT);
		live_s1  = use_s1 && !free_s1;
		aged_sum = {1'b0, slot_rd_data.elapsed} + (ELAPSED_W+1)'(tick_q);
		aged     = aged_sum[ELAPSED_W] ? '1 : aged_sum[ELAPSED_W-1:0];
		go_s1    = live_s1 && (slot_rd_data.dirty || (slot_rd_data.ever_dirty &&
			((!slot_rd_data.no_inactivity && slot_rd_data.repeat_count != REPEAT_LIMIT) ||
			 aged >= interval_q)));

		upd_s1         = slot_rd_data;
		upd_s1.elapsed = aged;
		if (go_s1) begin
			upd_s1.dirty   = 1'b0;
			upd_s1.elapsed = '0;
			if (slot_rd_data.dirty) begin
				upd_s1.repeat_count = '0;
			end else if (slot_rd_data.repeat_count != REPEAT_LIMIT) begin
				upd_s1.repeat_count = slot_rd_data.repeat_count + 1'b1;
			end
			if (slot_rd_data.terminated) begin
				upd_s1.term_sends = slot_rd_data.term_sends + 1'b1;
			end
		end
	end

	assign grp_rd_addr = GRP_W'(slot_rd_data.group);

	// walk stage 2: sequence number arrives, emit and write back
	logic              v_s2_q;
	logic              live_s2;
	logic              go_s2;
	logic [SLOT_W-1:0] idx_s2;
	slot_word_t        word_s2;
	logic [GRP_W-1:0]  grp_s2;

	logic [SEQ_GROUP_COUNT-1:0] grp_valid_q;
	logic                       fwd_v_q;
	logic [GRP_W-1:0]           fwd_grp_q;
	logic [SEQ_W-1:0]           fwd_seq_q;
	logic [SEQ_W-1:0]           seq_s2;

	// the counter written for the preceding slot is not yet visible in the ram read
	always_comb begin
		if (fwd_v_q && fwd_grp_q == grp_s2) begin
			seq_s2 = fwd_seq_q;
		end else if (grp_valid_q[grp_s2]) begin
			seq_s2 = grp_rd_data;
		end else begin
			seq_s2 = '0;
		end
	end

	assign grp_wr_en   = v_s2_q && go_s2;
	assign grp_wr_addr = grp_s2;
	assign grp_wr_data = seq_s2 + 1'b1;

	always_ff @(posedge clk) begin
		idx_s1    <= idx;
		idx_s2    <= idx_s1;
		live_s2   <= live_s1;
		go_s2     <= go_s1;
		word_s2   <= upd_s1;
		grp_s2    <= grp_rd_addr;
		fwd_grp_q <= grp_s2;
		fwd_seq_q <= grp_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			fwd_v_q     <= 1'b0;
			grp_valid_q <= '0;
		end else begin
			v_s1_q  <= ctl.walk_rd;
			v_s2_q  <= v_s1_q;
			fwd_v_q <= grp_wr_en;
			if (grp_wr_en) begin
				grp_valid_q[grp_s2] <= 1'b1;
			end
		end
	end

	// in-use bits: set by create, cleared when the walk frees a slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else begin
			if (ctl.create_wr) begin
				in_use_q[idx] <= 1'b1;
			end
			if (v_s1_q && free_s1) begin
				in_use_q[idx_s1] <= 1'b0;
			end
		end
	end

	// slot ram ports
	slot_word_t new_word;
	slot_word_t flag_word;

	always_comb begin
		new_word               = '0;
		new_word.universe      = item_q.universe_number;
		new_word.group         = grp_red;
		new_word.no_inactivity = item_q.skip_repeats;

		flag_word = slot_rd_data;
		if (item_q.cmd == CMD_DIRTY) begin
			flag_word.dirty      = 1'b1;
			flag_word.ever_dirty = 1'b1;
		end else begin
			flag_word.terminated = 1'b1;
		end

		slot_rd_addr = ctl.rmw_rd ? s_idx : idx;

		slot_wr_en   = v_s2_q && live_s2;
		slot_wr_addr = idx_s2;
		slot_wr_data = word_s2;
		if (ctl.create_wr) begin
			slot_wr_en   = 1'b1;
			slot_wr_addr = idx;
			slot_wr_data = new_word;
		end else if (ctl.rmw_wr && rmw_ok) begin
			slot_wr_en   = 1'b1;
			slot_wr_addr = s_idx;
			slot_wr_data = flag_word;
		end
	end

	// results: a send is held back in a register so that the last one can be marked
	result_t reply_res;
	result_t send_res;
	result_t last_res;
	result_t held_q;
	logic    held_v_q;
	logic    emit_send;
	logic    emit_flush;

	always_comb begin
		reply_res          = '0;
		reply_res.kind     = KIND_REPLY;
		reply_res.out_slot = (ctl.status == CS_OK) ? SLOT_IN_W'(idx) : '0;
		reply_res.status   = ctl.status;
		reply_res.last     = 1'b1;

		send_res              = '0;
		send_res.kind         = KIND_SEND;
		send_res.out_slot     = SLOT_IN_W'(idx_s2);
		send_res.out_universe = word_s2.universe;
		send_res.sequence_res = seq_s2;
		send_res.terminating  = word_s2.terminated;
		send_res.status       = CS_OK;

		last_res      = held_q;
		last_res.last = 1'b1;
	end

	assign emit_send  = v_s2_q && go_s2;
	assign emit_flush = ctl.flush && held_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
			held_v_q      <= 1'b0;
		end else begin
			result_strobe <= ctl.reply || (emit_send && held_v_q) || emit_flush;
			if (emit_send) begin
				held_v_q <= 1'b1;
			end else if (ctl.flush) begin
				held_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.reply) begin
			result <= reply_res;
		end else if (emit_send) begin
			result <= held_q;
		end else if (emit_flush) begin
			result <= last_res;
		end
		if (emit_send) begin
			held_q <= send_res;
		end
	end

	assign sts.uni_zero  = (item_q.universe_number == '0);
	assign sts.slot_free = !in_use_q[idx];
	assign sts.walk_busy = v_s1_q || v_s2_q;

endmodule

// ===== hdl/stream_universe_send_scheduler.sv =====
// stream universe send scheduler, top level; depends on suss_pkg, suss_ctrl, suss_dpath
// create: reply strobed when the free-slot scan ends
// tick: busy for the walk, drain and flush (one slot per cycle through a two-stage walk)
// dirty and terminate: busy for a read-modify-write of one slot table entry
// results are strobed for one cycle each; the receiver cannot stall
// reset: asynchronous, active low; slot table empty, counters and sequence numbers zero
module stream_universe_send_scheduler #(
	parameter int NUM_SLOTS       = suss_pkg::NUM_SLOTS_DEF,
	parameter int SEQ_GROUP_COUNT = suss_pkg::SEQ_GROUP_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  suss_pkg::item_t                 item,
	output logic                            result_strobe,
	output suss_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [suss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [suss_pkg::CFG_DATA_W-1:0] cfg_data
);
	import suss_pkg::*;

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	ctl_t              ctl;
	sts_t              sts;
	logic [SLOT_W-1:0] idx;

	assign cfg_ready = 1'b1;

	suss_ctrl #(
		.NUM_SLOTS (NUM_SLOTS),
		.SLOT_W    (SLOT_W)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (item.cmd),
		.sts    (sts),
		.busy   (busy),
		.ctl    (ctl),
		.idx    (idx)
	);

	suss_dpath #(
		.NUM_SLOTS       (NUM_SLOTS),
		.SEQ_GROUP_COUNT (SEQ_GROUP_COUNT),
		.SLOT_W          (SLOT_W)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.ctl           (ctl),
		.idx           (idx),
		.sts           (sts),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.result        (result)
	);

endmodule
